FILE: rtl/cje_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and fixed-point helpers for the cubic Julia escape-time core.
package cje_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 24;
  localparam int COUNT_BITS = 10;
  localparam int CODE_W     = 12;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int SHR_W      = PROD_W - FRAC_BITS;
  localparam int K3A_W      = DATA_WIDTH + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int N_SLOTS    = 4;
  localparam int TAG_W      = $clog2(N_SLOTS) + 1;
  localparam int IN_TDATA_W  = 2 * DATA_WIDTH;
  localparam int OUT_TDATA_W = ((CODE_W + 7) / 8) * 8;

  // Escape radius squared (10) at 2*FRAC_BITS fraction bits
  localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(10) << (2 * FRAC_BITS);

  // Code for a point that stayed bounded up to the limit
  localparam logic [CODE_W-1:0] CODE_BOUNDED = '1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_A       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_B       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_NEGATIVE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_B_IMAGINARY   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER      = CFG_IDX_W'(4);

  localparam logic [COUNT_BITS-1:0] MAX_ITER_RST = COUNT_BITS'(100);

  // Control that travels with each slot round the iteration ring
  typedef struct packed {
    logic                  valid;
    logic                  done;
    logic [TAG_W-1:0]      tag;
    logic [COUNT_BITS-1:0] cnt;
    logic [CODE_W-1:0]     code;
  } slot_ctrl_t;

  // Saturate a wide signed value to DATA_WIDTH bits
  function automatic logic signed [DATA_WIDTH-1:0] sat_w(input logic signed [SHR_W-1:0] v);
    logic signed [SHR_W-1:0] mx;
    logic signed [SHR_W-1:0] mn;
    mx = SHR_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    mn = -mx - SHR_W'(1);
    if (v > mx) begin
      sat_w = mx[DATA_WIDTH-1:0];
    end else if (v < mn) begin
      sat_w = mn[DATA_WIDTH-1:0];
    end else begin
      sat_w = v[DATA_WIDTH-1:0];
    end
  endfunction

  // Full product to fixed point: floor shift by FRAC_BITS, then saturate
  function automatic logic signed [DATA_WIDTH-1:0] fx_scale(input logic signed [PROD_W-1:0] p);
    fx_scale = sat_w($signed(p[PROD_W-1:FRAC_BITS]));
  endfunction

endpackage

FILE: rtl/cubic_julia_escape_time_core.sv
`timescale 1ns / 1ps
// Cubic Julia escape-time core: config registers, four-stage iteration ring, output register.
//
// Usage: start points arrive on the s_axis channel, one word per point holding z_re and z_im
// in Q8.24. Each point is iterated under z <- z*(z^2 - 3A) + b until it leaves radius^2 10
// or reaches max_iter; the escape code (-1, or twice the count) leaves on m_axis, one word
// per point, in the order the points came in.
// The config channel writes one register per handshake (index, data) and is always ready;
// writes to unknown indexes are dropped. The user makes writes while the core holds no
// point; the core does not enforce this. Timing: one iteration goes once round a ring of
// four register stages (square products, escape test and t1/t2, cross products, sums and
// saturation). Four points share the ring, so while all four slots hold points still
// iterating the aggregate rate is one iteration per cycle. A point's result word also waits
// behind any older point that is still iterating. Throughput is set by the ring, which
// takes new points while others are in flight, up to four at once.
// Reset empties the ring and the output register and loads the register defaults
// (a = 0, b = 0, lead negative, b on the real part, limit 100).
// Receiver stall: a finished point keeps circulating in the ring until the output register
// frees; its slot stays occupied, so s_axis_tready is low each time that slot comes round.
module cubic_julia_escape_time_core import cje_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // start points
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] z_re, [63:32] z_im
  // results
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [11:0] escape_code, [15:12] zero
  // register writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [DATA_WIDTH-1:0]  cfg_data_i
);

  // ---------------------------------------------------------------- registers
  logic signed [DATA_WIDTH-1:0] coeff_a_q, coeff_b_q;
  logic                         lead_neg_q, b_imag_q;
  logic [COUNT_BITS-1:0]        max_iter_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_a_q  <= '0;
      coeff_b_q  <= '0;
      lead_neg_q <= 1'b1;
      b_imag_q   <= 1'b0;
      max_iter_q <= MAX_ITER_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_COEFF_A:       coeff_a_q  <= $signed(cfg_data_i);
        CFG_COEFF_B:       coeff_b_q  <= $signed(cfg_data_i);
        CFG_LEAD_NEGATIVE: lead_neg_q <= cfg_data_i[0];
        CFG_B_IMAGINARY:   b_imag_q   <= cfg_data_i[0];
        CFG_MAX_ITER:      max_iter_q <= cfg_data_i[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // 3A, derived in steps: a*a registered in a2_q, then scaled, tripled and signed into k3a_q.
  // Settles before a point accepted after the write reaches the t1 stage.
  logic signed [PROD_W-1:0]     a2_q;
  logic signed [K3A_W-1:0]      k3a_d, k3a_q;
  logic signed [DATA_WIDTH-1:0] a_sq;
  logic signed [K3A_W-1:0]      a_sq3;

  always_comb begin
    a_sq  = fx_scale(a2_q);
    a_sq3 = K3A_W'(a_sq) + K3A_W'(a_sq) + K3A_W'(a_sq);
    k3a_d = lead_neg_q ? -a_sq3 : a_sq3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a2_q  <= '0;
      k3a_q <= '0;
    end else begin
      a2_q  <= coeff_a_q * coeff_a_q;
      k3a_q <= k3a_d;
    end
  end

  // ---------------------------------------------------------------- iteration ring
  slot_ctrl_t r1_ctrl_d, r1_ctrl_q, r2_ctrl_q, r3_ctrl_d, r3_ctrl_q, r4_ctrl_q;

  logic signed [DATA_WIDTH-1:0] r1_re_d, r1_im_d, r1_re_q, r1_im_q;
  logic signed [DATA_WIDTH-1:0] r2_re_q, r2_im_q, r3_re_q, r3_im_q;
  logic signed [PROD_W-1:0]     r2_prr_q, r2_pii_q, r2_pri_q;
  logic signed [DATA_WIDTH-1:0] r3_t1_d, r3_t2_d, r3_t1_q, r3_t2_q;
  logic signed [PROD_W-1:0]     r4_p1_q, r4_p2_q, r4_p3_q, r4_p4_q;

  logic [TAG_W-1:0] in_tag_q, out_tag_q;
  logic             out_valid_q;
  logic [CODE_W-1:0] out_code_q;

  logic release_w, slot_free, accept_in, inside_w;
  logic signed [DATA_WIDTH-1:0] b_re, b_im, nre, nim;
  logic [PROD_W-1:0]            mag_sum;
  logic signed [DATA_WIDTH-1:0] rr, ii, ri;

  // Stage 2 -> 3: escape test on exact squares, t1 and t2; done decision
  always_comb begin
    mag_sum  = $unsigned(r2_prr_q) + $unsigned(r2_pii_q);
    inside_w = mag_sum < ESC_LIMIT;
    rr       = fx_scale(r2_prr_q);
    ii       = fx_scale(r2_pii_q);
    ri       = fx_scale(r2_pri_q);
    r3_t1_d  = sat_w(SHR_W'(rr) - SHR_W'(ii) - SHR_W'(k3a_q));
    r3_t2_d  = sat_w(SHR_W'(ri) + SHR_W'(ri));

    r3_ctrl_d = r2_ctrl_q;
    if (r2_ctrl_q.valid && !r2_ctrl_q.done) begin
      if (r2_ctrl_q.cnt >= max_iter_q) begin
        r3_ctrl_d.done = 1'b1;
        r3_ctrl_d.code = CODE_BOUNDED;
      end else if (!inside_w) begin
        r3_ctrl_d.done = 1'b1;
        r3_ctrl_d.code = {1'b0, r2_ctrl_q.cnt, 1'b0};
      end else begin
        r3_ctrl_d.cnt = r2_ctrl_q.cnt + COUNT_BITS'(1);
      end
    end
  end

  // Stage 4 -> 1: sums with b, release of finished points, entry of new points
  always_comb begin
    b_re = b_imag_q ? '0 : coeff_b_q;
    b_im = b_imag_q ? coeff_b_q : '0;
    nre  = sat_w(SHR_W'(fx_scale(r4_p1_q)) - SHR_W'(fx_scale(r4_p2_q)) + SHR_W'(b_re));
    nim  = sat_w(SHR_W'(fx_scale(r4_p3_q)) + SHR_W'(fx_scale(r4_p4_q)) + SHR_W'(b_im));

    // oldest point leaves once the output register can take it
    release_w = r4_ctrl_q.valid && r4_ctrl_q.done && (r4_ctrl_q.tag == out_tag_q) &&
                (!out_valid_q || m_axis_tready);
    slot_free = !r4_ctrl_q.valid || release_w;
    accept_in = s_axis_tvalid && slot_free;

    r1_ctrl_d = r4_ctrl_q;
    r1_re_d   = nre;
    r1_im_d   = nim;
    if (accept_in) begin
      r1_ctrl_d       = '0;
      r1_ctrl_d.valid = 1'b1;
      r1_ctrl_d.tag   = in_tag_q;
      r1_re_d         = $signed(s_axis_tdata[DATA_WIDTH-1:0]);
      r1_im_d         = $signed(s_axis_tdata[IN_TDATA_W-1:DATA_WIDTH]);
    end else if (release_w) begin
      r1_ctrl_d = '0;
    end
  end

  assign s_axis_tready = slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_ctrl_q   <= '0;
      r2_ctrl_q   <= '0;
      r3_ctrl_q   <= '0;
      r4_ctrl_q   <= '0;
      in_tag_q    <= '0;
      out_tag_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      r1_ctrl_q <= r1_ctrl_d;
      r2_ctrl_q <= r1_ctrl_q;
      r3_ctrl_q <= r3_ctrl_d;
      r4_ctrl_q <= r3_ctrl_q;
      if (accept_in) begin
        in_tag_q <= in_tag_q + TAG_W'(1);
      end
      if (release_w) begin
        out_tag_q   <= out_tag_q + TAG_W'(1);
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    r1_re_q  <= r1_re_d;
    r1_im_q  <= r1_im_d;
    // stage 1 -> 2: squares and cross product
    r2_re_q  <= r1_re_q;
    r2_im_q  <= r1_im_q;
    r2_prr_q <= r1_re_q * r1_re_q;
    r2_pii_q <= r1_im_q * r1_im_q;
    r2_pri_q <= r1_re_q * r1_im_q;
    r3_re_q  <= r2_re_q;
    r3_im_q  <= r2_im_q;
    r3_t1_q  <= r3_t1_d;
    r3_t2_q  <= r3_t2_d;
    // stage 3 -> 4: t1/t2 times the point
    r4_p1_q  <= r3_t1_q * r3_re_q;
    r4_p2_q  <= r3_t2_q * r3_im_q;
    r4_p3_q  <= r3_t1_q * r3_im_q;
    r4_p4_q  <= r3_t2_q * r3_re_q;
    if (release_w) begin
      out_code_q <= r4_ctrl_q.code;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_code_q);

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the cubic Julia escape-time core: scripted and random points.
module tb import cje_pkg::*; ();

  // Q8.24 values used by the script
  localparam logic [DATA_WIDTH-1:0] Q_ZERO      = 32'h0000_0000;
  localparam logic [DATA_WIDTH-1:0] Q_HALF      = 32'h0080_0000;
  localparam logic [DATA_WIDTH-1:0] Q_ONE       = 32'h0100_0000;
  localparam logic [DATA_WIDTH-1:0] Q_MINUS_ONE = 32'hFF00_0000;
  localparam logic [DATA_WIDTH-1:0] Q_THREE     = 32'h0300_0000;
  localparam logic [DATA_WIDTH-1:0] Q_FOUR      = 32'h0400_0000;
  localparam logic [DATA_WIDTH-1:0] W_MAX       = 32'h7FFF_FFFF;
  localparam logic [DATA_WIDTH-1:0] W_MIN       = 32'h8000_0000;

  // Indexes past the register list; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = CFG_IDX_W'(7);

  localparam logic [CODE_W-1:0] NO_CODE  = '0;
  localparam int                LIMIT_RST = 100;
  localparam int                N_PHASES  = 10;
  localparam int                N_SCRIPT  = 32;
  // worst gap between words comes from one lone point at 1023 iterations
  localparam int                STALL_LIMIT = 25000;
  localparam longint unsigned   RADIUS2 = 64'd10 << (2 * FRAC_BITS);

  typedef enum logic {ROW_POINT, ROW_WRITE} row_kind_e;

  // Point rows: w0 = z_re, w1 = z_im. Write rows: w0 = register index, w1 = data.
  typedef struct packed {
    row_kind_e             kind;
    logic [31:0]           w0;
    logic [31:0]           w1;
    logic                  fixed;
    logic [CODE_W-1:0]     code;
  } row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [DATA_WIDTH-1:0]  cfg_data_i = '0;

  // Travels beside s_axis_tdata: a code typed into the script overrides the predictor
  logic                   drv_fixed = 1'b0;
  logic [CODE_W-1:0]      drv_code = '0;

  // Predictor's copy of the register file, reset defaults
  longint                 julia_a = 0;
  longint                 julia_b = 0;
  bit                     lead_neg = 1'b1;
  bit                     b_on_imag = 1'b0;
  int                     iter_limit = LIMIT_RST;

  logic [CODE_W-1:0]      codes_due [$];
  int                     fail_count = 0;
  int                     words_out = 0;
  int                     quiet_cycles = 0;
  bit                     idle_on = 1'b1;

  row_t script [N_SCRIPT] = '{
    // reset settings: A = 0, b = 0, limit 100, so the map is plain z^3
    '{ROW_POINT, Q_ZERO,      Q_ZERO,      1'b1, CODE_BOUNDED},  // fixed point at origin
    '{ROW_POINT, Q_ONE,       Q_ZERO,      1'b1, CODE_BOUNDED},  // 1^3 = 1
    '{ROW_POINT, Q_MINUS_ONE, Q_ZERO,      1'b1, CODE_BOUNDED},  // (-1)^3 = -1
    '{ROW_POINT, Q_THREE,     Q_ZERO,      1'b1, CODE_W'(2)},    // 27 escapes after one step
    '{ROW_POINT, Q_ZERO,      Q_THREE,     1'b1, CODE_W'(2)},    // -27i likewise
    '{ROW_POINT, Q_THREE,     Q_ONE,       1'b1, CODE_W'(0)},    // exactly on radius^2 = 10
    '{ROW_POINT, Q_THREE,     32'h00FF_FFFF, 1'b0, NO_CODE},     // one lsb inside the radius
    '{ROW_POINT, W_MAX,       W_MAX,       1'b1, CODE_W'(0)},
    '{ROW_POINT, W_MIN,       W_MIN,       1'b1, CODE_W'(0)},
    '{ROW_POINT, W_MIN,       Q_ZERO,      1'b1, CODE_W'(0)},
    '{ROW_POINT, Q_HALF,      Q_HALF,      1'b0, NO_CODE},
    '{ROW_POINT, 32'h0123_4567, 32'hFEDC_BA98, 1'b0, NO_CODE},
    // zero limit: bounded code whatever the point
    '{ROW_WRITE, 32'(CFG_MAX_ITER), 32'd0, 1'b0, NO_CODE},
    '{ROW_POINT, Q_ZERO,      Q_ZERO,      1'b1, CODE_BOUNDED},
    '{ROW_POINT, W_MAX,       W_MAX,       1'b1, CODE_BOUNDED},
    // limit of one step
    '{ROW_WRITE, 32'(CFG_MAX_ITER), 32'd1, 1'b0, NO_CODE},
    '{ROW_POINT, Q_THREE,     Q_ZERO,      1'b1, CODE_BOUNDED},
    '{ROW_POINT, Q_FOUR,      Q_ZERO,      1'b1, CODE_W'(0)},
    // extreme coefficients, saturating intermediates, largest limit
    '{ROW_WRITE, 32'(CFG_COEFF_A),  W_MIN, 1'b0, NO_CODE},
    '{ROW_WRITE, 32'(CFG_COEFF_B),  W_MAX, 1'b0, NO_CODE},
    '{ROW_WRITE, 32'(CFG_MAX_ITER), 32'd1023, 1'b0, NO_CODE},
    '{ROW_POINT, Q_ZERO,      Q_ZERO,      1'b0, NO_CODE},
    '{ROW_WRITE, 32'(CFG_LEAD_NEGATIVE), 32'd0, 1'b0, NO_CODE},
    '{ROW_WRITE, 32'(CFG_B_IMAGINARY),   32'd1, 1'b0, NO_CODE},
    '{ROW_POINT, Q_ZERO,      Q_ZERO,      1'b0, NO_CODE},
    '{ROW_POINT, Q_HALF,      Q_MINUS_ONE, 1'b0, NO_CODE},
    '{ROW_WRITE, 32'(CFG_COEFF_A),  W_MAX, 1'b0, NO_CODE},
    '{ROW_WRITE, 32'(CFG_COEFF_B),  W_MIN, 1'b0, NO_CODE},
    '{ROW_POINT, Q_ONE,       Q_ONE,       1'b0, NO_CODE},
    // unknown indexes: the same point must give the same code
    '{ROW_WRITE, 32'(CFG_UNUSED_LO), 32'h0000_0000, 1'b0, NO_CODE},
    '{ROW_WRITE, 32'(CFG_UNUSED_HI), 32'hFFFF_FFFF, 1'b0, NO_CODE},
    '{ROW_POINT, Q_ONE,       Q_ONE,       1'b0, NO_CODE}
  };

  cubic_julia_escape_time_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clip_word(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // exact product, floor shift by the fraction bits, saturate
  function automatic longint fx_mul_floor(input longint x, input longint y);
    return clip_word((x * y) >>> FRAC_BITS);
  endfunction

  // escape test on exact squares; the sum can reach 2^63, hence unsigned
  function automatic bit below_radius(input longint re, input longint im);
    longint unsigned mag2;
    mag2 = re * re;
    mag2 = mag2 + longint'(im * im);
    return mag2 < RADIUS2;
  endfunction

  function automatic logic [CODE_W-1:0] predict_escape_code(input logic [IN_TDATA_W-1:0] word);
    longint re;
    longint im;
    longint lead;
    longint b_re;
    longint b_im;
    longint t1;
    longint t2;
    longint nre;
    int     n;
    re   = longint'($signed(word[DATA_WIDTH-1:0]));
    im   = longint'($signed(word[2*DATA_WIDTH-1:DATA_WIDTH]));
    lead = fx_mul_floor(julia_a, julia_a);
    if (lead_neg) lead = -lead;
    b_re = b_on_imag ? 0 : julia_b;
    b_im = b_on_imag ? julia_b : 0;
    n = 0;
    while (n < iter_limit && below_radius(re, im)) begin
      t1  = clip_word(fx_mul_floor(re, re) - fx_mul_floor(im, im) - 3 * lead);
      t2  = clip_word(2 * fx_mul_floor(re, im));
      nre = clip_word(fx_mul_floor(t1, re) - fx_mul_floor(t2, im) + b_re);
      im  = clip_word(fx_mul_floor(t1, im) + fx_mul_floor(t2, re) + b_im);
      re  = nre;
      n++;
    end
    if (n >= iter_limit) return CODE_BOUNDED;
    return CODE_W'(2 * n);
  endfunction

  // ---------------------------------------------------------------- monitor
  // Everything is sampled at the rising edge; inputs only move on the falling one.

  always @(posedge clk_i) begin : monitor_b
    logic [CODE_W-1:0] want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_COEFF_A:       julia_a = longint'($signed(cfg_data_i));
          CFG_COEFF_B:       julia_b = longint'($signed(cfg_data_i));
          CFG_LEAD_NEGATIVE: lead_neg = cfg_data_i[0];
          CFG_B_IMAGINARY:   b_on_imag = cfg_data_i[0];
          CFG_MAX_ITER:      iter_limit = int'(cfg_data_i[COUNT_BITS-1:0]);
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        codes_due.push_back(drv_fixed ? drv_code : predict_escape_code(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (codes_due.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected result word %0d: code %0d", words_out,
                     $signed(m_axis_tdata[CODE_W-1:0]));
          end
          fail_count++;
        end else begin
          want = codes_due.pop_front();
          if (m_axis_tdata[CODE_W-1:0] !== want) begin
            if (fail_count < 10) begin
              $display("result word %0d: escape_code expected %0d, got %0d", words_out,
                       $signed(want), $signed(m_axis_tdata[CODE_W-1:0]));
            end
            fail_count++;
          end
        end
        words_out++;
      end
    end
  end

  // watchdog: any accepted word on any channel restarts the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("cubic_julia_escape_time_core regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver back-pressure in random bursts
  initial begin : sink_b
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 6) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  // All tasks start and end on a falling edge.

  task automatic push_point(input logic [31:0] re, input logic [31:0] im,
                            input logic fixed, input logic [CODE_W-1:0] code);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {im, re};
    drv_fixed     <= fixed;
    drv_code      <= code;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // registers change only with the core empty
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (codes_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // mostly within +/- span/2, with extremes and fully random words mixed in
  function automatic logic [31:0] random_fixed(input logic [31:0] span);
    case ($urandom_range(0, 9))
      0: return W_MIN;
      1: return W_MAX;
      2: return Q_ZERO;
      3: return $urandom();
      default: return 32'($urandom_range(0, span)) - (span >> 1);
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  initial begin : stim_b
    int          lim;
    int          n_points;
    logic [31:0] lim_word;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // scripted part
    for (int r = 0; r < N_SCRIPT; r++) begin
      if (script[r].kind == ROW_WRITE) begin
        drain_results();
        write_reg(script[r].w0[CFG_IDX_W-1:0], script[r].w1);
      end else begin
        push_point(script[r].w0, script[r].w1, script[r].fixed, script[r].code);
      end
    end

    // random phases; the last one runs with no idling on either side
    for (int phase = 0; phase < N_PHASES; phase++) begin
      drain_results();
      if (phase == N_PHASES - 1) idle_on = 1'b0;
      write_reg(CFG_COEFF_A, random_fixed(32'h0300_0000));
      write_reg(CFG_COEFF_B, random_fixed(32'h0400_0000));
      write_reg(CFG_LEAD_NEGATIVE, 32'($urandom_range(0, 1)));
      write_reg(CFG_B_IMAGINARY, 32'($urandom_range(0, 1)));
      case ($urandom_range(0, 9))
        0: lim = 1023;
        1: lim = 0;
        2: lim = LIMIT_RST;
        default: lim = $urandom_range(1, 60);
      endcase
      lim_word = 32'(lim);
      write_reg(CFG_MAX_ITER, lim_word);
      // long limits keep the phase short, since bounded points go round the ring once a step
      n_points = (lim > 200) ? 16 : 85;
      for (int k = 0; k < n_points; k++) begin
        push_point(random_fixed(32'h0400_0000), random_fixed(32'h0400_0000), 1'b0, NO_CODE);
      end
    end

    drain_results();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && codes_due.size() == 0) begin
      $display("cubic_julia_escape_time_core regression: pass");
    end else begin
      $display("cubic_julia_escape_time_core regression: fail");
    end
    $finish;
  end

endmodule
